@@ rtl/gbn_pkg.sv @@
// Package for the go-back-n sender: payload structs, opcodes, states,
// register indexes and reset values. No dependencies.
`timescale 1ns / 1ps
package gbn_pkg;

    localparam int SEQ_W        = 8;
    localparam int CNT_W        = 5;
    localparam int RESULT_LIMIT = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_ACKS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ADAPT_AFTER     = 3'd4;

    localparam logic [1:0] MODE_OFFER = 2'd0;
    localparam logic [1:0] MODE_ACK   = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam logic [4:0]  WINDOW_RST  = 5'd10;
    localparam logic [31:0] TIMEOUT_RST = 32'd100000;
    localparam logic [3:0]  MAXATT_RST  = 4'd5;
    localparam logic [15:0] TOTAL_RST   = 16'd40;
    localparam logic [7:0]  ADAPT_RST   = 8'd10;

    typedef enum logic [1:0] {OP_OFFER, OP_ACK, OP_TICK, OP_NOP} t_op;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ACK_RD, ST_MUL, ST_ADD, ST_DIV, ST_TMO,
        ST_TICK_RD, ST_WALK_RD, ST_WALK_CHK, ST_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]       mode;
        logic [SEQ_W-1:0] ack_seq;
    } t_in_item;

    typedef struct packed {
        t_op              op;
        logic [SEQ_W-1:0] ack_seq;
    } t_cmd;

    typedef struct packed {
        logic             send_valid;
        logic [SEQ_W-1:0] send_seq;
        logic             is_retransmit;
        logic             offer_accepted;
        logic             ack_taken;
        logic             failed;
        logic             finished;
        logic [SEQ_W-1:0] window_base;
        logic [CNT_W-1:0] outstanding;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

@@ rtl/gbn_front.sv @@
// Front end: accepts input transfers, decodes the mode into an opcode and
// queues commands for the engine (two entries). Depends on gbn_pkg.
`timescale 1ns / 1ps
module gbn_front import gbn_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    output logic     o_full,
    input  t_in_item i_in,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_pop
);
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       cmd_in;
    logic       do_wr, do_rd;

    always_comb begin
        cmd_in.ack_seq = i_in.ack_seq;
        unique case (i_in.mode)
            MODE_OFFER: cmd_in.op = OP_OFFER;
            MODE_ACK:   cmd_in.op = OP_ACK;
            MODE_TICK:  cmd_in.op = OP_TICK;
            default:    cmd_in.op = OP_NOP;
        endcase
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_mem[r_rp];
    assign do_wr       = i_push && !o_full;
    assign do_rd       = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_wr) r_wp <= ~r_wp;
            if (do_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end
endmodule

@@ rtl/gbn_out_q.sv @@
// Result queue: four entries between the engine and the result port.
// Depends on gbn_pkg.
`timescale 1ns / 1ps
module gbn_out_q import gbn_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_wr,
    input  t_out_item i_item,
    output logic      o_full,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_item
);
    t_out_item  r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       do_wr, do_rd;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_item  = r_mem[r_rp];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (do_wr) r_wp <= r_wp + 2'd1;
            if (do_rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b0, do_wr} - {2'b0, do_rd};
        end
    end
endmodule

@@ rtl/gbn_engine.sv @@
// Back end: window state, stamp/attempt memory, RTT mean with serial
// divider, resend walk and result emission. Depends on gbn_pkg.
`timescale 1ns / 1ps
module gbn_engine import gbn_pkg::*; #(
    parameter int MAX_WINDOW = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg_wr   i_cfg,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_res_push,
    output t_out_item o_res,
    input  logic      i_res_full
);
    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W  = ((SLOT_W > CNT_W) ? SLOT_W : CNT_W) + 1;
    localparam int LIM    = (MAX_WINDOW < RESULT_LIMIT) ? MAX_WINDOW : RESULT_LIMIT;
    localparam int DW     = TIME_BITS + 17;
    localparam int CW     = $clog2(DW);
    localparam logic [TIME_BITS-1:0] HALF = {1'b0, {(TIME_BITS-1){1'b1}}};

    // stamp / attempt memory
    logic [TIME_BITS-1:0] stamp_mem [MAX_WINDOW];
    logic [3:0]           att_mem   [MAX_WINDOW];
    logic                 mem_we;
    logic [SLOT_W-1:0]    mem_wa, mem_ra;
    logic [TIME_BITS-1:0] mem_stamp_wd;
    logic [3:0]           mem_att_wd;
    logic [TIME_BITS-1:0] r_rd_stamp;
    logic [3:0]           r_rd_att;

    t_state r_state, n_state;
    logic [4:0]  r_window, n_window;
    logic [31:0] r_init_to, n_init_to;
    logic [3:0]  r_max_att, n_max_att;
    logic [15:0] r_total, n_total;
    logic [7:0]  r_adapt, n_adapt;
    logic [SEQ_W-1:0]     r_base, n_base, r_next, n_next, r_start, n_start;
    logic [CNT_W-1:0]     r_pending, n_pending, r_nsend, n_nsend;
    logic [CNT_W-1:0]     r_k, n_k, r_walk_i, n_walk_i, r_off, n_off;
    logic [SLOT_W-1:0]    r_head, n_head;
    logic [TIME_BITS-1:0] r_clock, n_clock, r_mean, n_mean;
    logic [TIME_BITS-1:0] r_timeout, n_timeout, r_sample, n_sample;
    logic [15:0]          r_retired, n_retired, r_taken, n_taken, r_rem, n_rem;
    logic                 r_fail, n_fail, r_retx, n_retx, r_acc, n_acc, r_tkn, n_tkn;
    logic [DW-1:0]        r_prod, n_prod, r_quo, n_quo;
    logic [CW-1:0]        r_div_cnt, n_div_cnt;

    logic                 halted;
    logic [CNT_W-1:0]     eff_win, cnt, last_idx;
    logic [TIME_BITS-1:0] age, q_time;
    logic [16:0]          ret_sum, rem_sh;
    logic [TIME_BITS+15:0] prod_full;
    t_op                  op;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] head,
                                                   input logic [CNT_W-1:0] ofs);
        logic [SUM_W-1:0] s;
        s = SUM_W'(head) + SUM_W'(ofs);
        if (s >= SUM_W'(MAX_WINDOW)) s = s - SUM_W'(MAX_WINDOW);
        return s[SLOT_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            stamp_mem[mem_wa] <= mem_stamp_wd;
            att_mem[mem_wa]   <= mem_att_wd;
        end
        r_rd_stamp <= stamp_mem[mem_ra];
        r_rd_att   <= att_mem[mem_ra];
    end

    assign halted  = r_fail || (r_taken >= r_total);
    assign eff_win = (r_window == 5'd0) ? 5'd1 :
                     (r_window > CNT_W'(LIM)) ? CNT_W'(LIM) : r_window;
    assign cnt     = r_off + 5'd1;
    assign age     = r_clock - r_rd_stamp;
    assign ret_sum = {1'b0, r_retired} + 17'(cnt);
    assign prod_full = r_mean * (r_taken - 16'd1);
    assign rem_sh  = {r_rem, r_quo[DW-1]};
    assign q_time  = r_quo[TIME_BITS-1:0];
    assign last_idx = (r_nsend == 5'd0) ? 5'd0 : r_nsend - 5'd1;
    assign op      = halted ? OP_NOP : i_cmd.op;

    always_comb begin
        n_state = r_state;
        n_window = r_window; n_init_to = r_init_to; n_max_att = r_max_att;
        n_total = r_total;   n_adapt = r_adapt;
        n_base = r_base;     n_next = r_next;       n_start = r_start;
        n_pending = r_pending; n_nsend = r_nsend;   n_k = r_k;
        n_walk_i = r_walk_i; n_off = r_off;         n_head = r_head;
        n_clock = r_clock;   n_mean = r_mean;       n_timeout = r_timeout;
        n_sample = r_sample; n_retired = r_retired; n_taken = r_taken;
        n_rem = r_rem;       n_fail = r_fail;       n_retx = r_retx;
        n_acc = r_acc;       n_tkn = r_tkn;         n_prod = r_prod;
        n_quo = r_quo;       n_div_cnt = r_div_cnt;
        mem_we = 1'b0; mem_wa = r_head; mem_ra = r_head;
        mem_stamp_wd = r_clock; mem_att_wd = 4'd1;
        o_cmd_pop = 1'b0; o_res_push = 1'b0;

        o_res.send_valid     = (r_nsend != 5'd0);
        o_res.send_seq       = (r_nsend != 5'd0) ? r_start + SEQ_W'(r_k) : '0;
        o_res.is_retransmit  = (r_nsend != 5'd0) && r_retx;
        o_res.offer_accepted = r_acc;
        o_res.ack_taken      = r_tkn;
        o_res.failed         = r_fail;
        o_res.finished       = (r_taken >= r_total);
        o_res.window_base    = r_base;
        o_res.outstanding    = r_pending;
        o_res.last           = (r_k == last_idx);

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_nsend = '0; n_retx = 1'b0; n_acc = 1'b0; n_tkn = 1'b0; n_k = '0;
                    n_state = ST_EMIT;
                    unique case (op)
                        OP_OFFER: begin
                            if (r_pending < eff_win) begin
                                mem_we = 1'b1;
                                mem_wa = slot_of(r_head, r_pending);
                                n_start = r_next;
                                n_next = r_next + 8'd1;
                                n_pending = r_pending + 5'd1;
                                n_acc = 1'b1;
                                n_nsend = 5'd1;
                            end
                        end
                        OP_ACK: begin
                            if ((i_cmd.ack_seq - r_base) < {3'b0, r_pending}) begin
                                n_off = CNT_W'(i_cmd.ack_seq - r_base);
                                mem_ra = slot_of(r_head, CNT_W'(i_cmd.ack_seq - r_base));
                                n_state = ST_ACK_RD;
                            end
                        end
                        OP_TICK: begin
                            n_clock = r_clock + 1'b1;
                            if (r_pending != 5'd0) n_state = ST_TICK_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ACK_RD: begin
                n_sample  = age;
                n_head    = slot_of(r_head, cnt);
                n_base    = r_base + SEQ_W'(cnt);
                n_pending = r_pending - cnt;
                n_retired = ret_sum[16] ? 16'hFFFF : ret_sum[15:0];
                if (r_taken != 16'hFFFF) n_taken = r_taken + 16'd1;
                n_tkn   = 1'b1;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_prod  = DW'(prod_full);
                n_state = ST_ADD;
            end
            ST_ADD: begin
                n_quo     = r_prod + DW'(r_sample);
                n_rem     = '0;
                n_div_cnt = '0;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                if (rem_sh >= {1'b0, r_taken}) begin
                    n_rem = 16'(rem_sh - {1'b0, r_taken});
                    n_quo = {r_quo[DW-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[15:0];
                    n_quo = {r_quo[DW-2:0], 1'b0};
                end
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == CW'(DW-1)) n_state = ST_TMO;
            end
            ST_TMO: begin
                n_mean = q_time;
                if (r_taken > {8'b0, r_adapt}) begin
                    n_timeout = (q_time > HALF) ? '1 : {q_time[TIME_BITS-2:0], 1'b0};
                end
                n_state = ST_EMIT;
            end
            ST_TICK_RD: begin
                if (age > r_timeout) begin
                    n_retx   = 1'b1;
                    n_start  = r_base;
                    n_walk_i = '0;
                    n_state  = ST_WALK_RD;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_WALK_RD: begin
                mem_ra  = slot_of(r_head, r_walk_i);
                n_state = ST_WALK_CHK;
            end
            ST_WALK_CHK: begin
                if (r_rd_att > r_max_att) begin
                    n_fail  = 1'b1;
                    n_state = ST_EMIT;
                end else begin
                    mem_we     = 1'b1;
                    mem_wa     = slot_of(r_head, r_walk_i);
                    mem_att_wd = (r_rd_att == 4'd15) ? 4'd15 : r_rd_att + 4'd1;
                    n_nsend    = r_nsend + 5'd1;
                    n_walk_i   = r_walk_i + 5'd1;
                    n_state    = (r_walk_i + 5'd1 == r_pending) ? ST_EMIT : ST_WALK_RD;
                end
            end
            ST_EMIT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    if (r_k == last_idx) n_state = ST_IDLE;
                    else n_k = r_k + 5'd1;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // register writes are to arrive only while idle: a rule for the user, not enforced here
        if (i_cfg.we) begin
            unique case (i_cfg.idx)
                CFG_WINDOW_SIZE: n_window = i_cfg.data[4:0];
                CFG_INITIAL_TIMEOUT: begin
                    n_init_to = i_cfg.data;
                    if (r_taken <= {8'b0, r_adapt}) n_timeout = TIME_BITS'(i_cfg.data);
                end
                CFG_MAX_ATTEMPTS: n_max_att = i_cfg.data[3:0];
                CFG_TOTAL_ACKS:   n_total   = i_cfg.data[15:0];
                CFG_ADAPT_AFTER:  n_adapt   = i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_window <= WINDOW_RST; r_init_to <= TIMEOUT_RST; r_max_att <= MAXATT_RST;
            r_total <= TOTAL_RST;   r_adapt <= ADAPT_RST;
            r_base <= '0; r_next <= '0; r_pending <= '0; r_head <= '0;
            r_clock <= '0; r_mean <= '0; r_retired <= '0; r_taken <= '0;
            r_timeout <= TIME_BITS'(TIMEOUT_RST); r_fail <= 1'b0;
            r_nsend <= '0; r_k <= '0; r_walk_i <= '0; r_div_cnt <= '0;
            r_retx <= 1'b0; r_acc <= 1'b0; r_tkn <= 1'b0;
        end else begin
            r_state <= n_state;
            r_window <= n_window; r_init_to <= n_init_to; r_max_att <= n_max_att;
            r_total <= n_total;   r_adapt <= n_adapt;
            r_base <= n_base; r_next <= n_next; r_pending <= n_pending; r_head <= n_head;
            r_clock <= n_clock; r_mean <= n_mean; r_retired <= n_retired;
            r_taken <= n_taken; r_timeout <= n_timeout; r_fail <= n_fail;
            r_nsend <= n_nsend; r_k <= n_k; r_walk_i <= n_walk_i; r_div_cnt <= n_div_cnt;
            r_retx <= n_retx; r_acc <= n_acc; r_tkn <= n_tkn;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start; r_off <= n_off; r_sample <= n_sample;
        r_prod <= n_prod; r_quo <= n_quo; r_rem <= n_rem;
    end

    a_pending_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= CNT_W'(LIM)) else $error("outstanding beyond window limit");
    a_push_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> r_state == ST_EMIT) else $error("result push outside emit");
    a_walk_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WALK_CHK |-> r_walk_i < r_pending) else $error("walk overran");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && !i_res_full && o_res.last) |=> r_state == ST_IDLE)
        else $error("no return to idle after last result");
endmodule

@@ rtl/go_back_n_sender.sv @@
// Top level of the go-back-n sender scheduler: front command queue, engine,
// result queue. Depends on gbn_pkg, gbn_front, gbn_engine, gbn_out_q.
//
//  channel   ports                          transfer when
//  input     i_push, o_full, i_in            i_push && !o_full
//  result    o_empty, i_pop, o_out           i_pop && !o_empty
//  config    i_cfg_we, i_cfg_idx, i_cfg_data i_cfg_we
//
// Offer: decode, then its one result. Tick without resend: decode, timeout
// check, result; the check is skipped when nothing is outstanding.
// Ack: read, retire, multiply, add, bit-serial mean divider, new timeout, result.
// Resend walk: memory read then update for each outstanding entry,
// then one result per cycle. Results drain through a 4-entry queue; a full
// queue stalls the engine, a busy engine fills the 2-entry command queue.
// Reset is synchronous, active low; stamp/attempt memory has no reset.
`timescale 1ns / 1ps
module go_back_n_sender import gbn_pkg::*; #(
    parameter int MAX_WINDOW = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  t_in_item              i_in,
    output logic                  o_empty,
    input  logic                  i_pop,
    output t_out_item             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    logic      cmd_valid, cmd_pop, res_push, res_full;
    t_cmd      cmd;
    t_out_item res;
    t_cfg_wr   cfg;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    // front: accept and decode
    gbn_front u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_in,
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_pop(cmd_pop)
    );

    // back: one command at a time
    gbn_engine #(.MAX_WINDOW(MAX_WINDOW), .TIME_BITS(TIME_BITS)) u_engine (
        .i_clk, .i_rst_n, .i_cfg(cfg),
        .i_cmd_valid(cmd_valid), .i_cmd(cmd), .o_cmd_pop(cmd_pop),
        .o_res_push(res_push), .o_res(res), .i_res_full(res_full)
    );

    // result side
    gbn_out_q u_out_q (
        .i_clk, .i_rst_n, .i_wr(res_push), .i_item(res), .o_full(res_full),
        .o_empty, .i_pop, .o_item(o_out)
    );
endmodule

@@ dv/gbn_checker.sv @@
// Scoreboard for the go-back-n sender: watches the input, result and config
// channels, predicts the results of each input transfer and compares them.
// Depends on gbn_pkg.
`timescale 1ns / 1ps
module gbn_checker import gbn_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_full,
    input  t_in_item              i_in,
    input  logic                  i_empty,
    input  logic                  i_pop,
    input  t_out_item             i_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_results,
    output logic [SEQ_W-1:0]      o_base,
    output logic [CNT_W-1:0]      o_count
);

    logic [4:0]  win_reg;
    logic [31:0] init_tmo;
    logic [3:0]  max_att;
    logic [15:0] total_reg;
    logic [7:0]  adapt_reg;

    logic [7:0]  base_seq, next_seq;
    logic [4:0]  pend;
    logic [3:0]  head;
    logic [31:0] stamp [16];
    logic [3:0]  tries [16];
    logic [31:0] now, mean, tmo;
    logic [15:0] retired, taken_cnt;
    logic        fail_flag;

    t_out_item   sends_q [$];

    assign o_pending = sends_q.size();
    assign o_base    = base_seq;
    assign o_count   = pend;

    task automatic chk(input string nm, input int e, input int a);
        if (e != a) begin
            $display("%0t ns: field %s mismatch, expected %0d, actual %0d", $time, nm, e, a);
            o_errors++;
        end
    endtask

    task automatic predict_sends(input t_in_item it);
        logic [7:0]  seqs [16];
        logic [4:0]  w;
        logic [4:0]  off;
        logic [3:0]  s;
        logic [31:0] sample;
        logic [63:0] acc;
        int          nsend, nres, i;
        logic        retx, acc_ok, took, halted;
        t_out_item   r;
        nsend = 0; retx = 0; acc_ok = 0; took = 0;
        halted = fail_flag || (taken_cnt >= total_reg);
        w = (win_reg == 0) ? 5'd1 : (win_reg > 16) ? 5'd16 : win_reg;
        if (!halted && it.mode == MODE_OFFER) begin
            if (pend < w) begin
                s = head + pend[3:0];
                stamp[s] = now;
                tries[s] = 1;
                seqs[nsend++] = next_seq;
                next_seq++;
                pend++;
                acc_ok = 1;
            end
        end else if (!halted && it.mode == MODE_ACK) begin
            off = {1'b0, 4'(it.ack_seq - base_seq)};
            if (8'(it.ack_seq - base_seq) < pend) begin
                sample = now - stamp[head + off[3:0]];
                head += 4'(off + 1);
                base_seq += 8'(off + 1);
                pend -= off + 1;
                retired = (int'(retired) + off + 1 > 65535) ? 16'hFFFF : retired + off + 1;
                if (taken_cnt != 16'hFFFF) taken_cnt++;
                // running mean over all taken acks, wide intermediate
                acc = 64'(mean) * 64'(taken_cnt - 1) + 64'(sample);
                mean = 32'(acc / 64'(taken_cnt));
                if (taken_cnt > adapt_reg)
                    tmo = (mean > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : mean << 1;
                took = 1;
            end
        end else if (!halted && it.mode == MODE_TICK) begin
            now++;
            if (pend > 0 && (now - stamp[head]) > tmo) begin
                for (i = 0; i < pend; i++) begin
                    s = head + 4'(i);
                    if (tries[s] > max_att) begin
                        fail_flag = 1;
                        break;
                    end
                    stamp[s] = now;
                    if (tries[s] != 4'd15) tries[s]++;
                    seqs[nsend++] = base_seq + 8'(i);
                end
                retx = 1;
            end
        end
        nres = (nsend > 0) ? nsend : 1;
        for (i = 0; i < nres; i++) begin
            r.send_valid     = nsend > 0;
            r.send_seq       = (nsend > 0) ? seqs[i] : 8'd0;
            r.is_retransmit  = (nsend > 0) && retx;
            r.offer_accepted = acc_ok;
            r.ack_taken      = took;
            r.failed         = fail_flag;
            r.finished       = taken_cnt >= total_reg;
            r.window_base    = base_seq;
            r.outstanding    = pend;
            r.last           = (i == nres - 1);
            sends_q.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            win_reg = WINDOW_RST; init_tmo = TIMEOUT_RST; max_att = MAXATT_RST;
            total_reg = TOTAL_RST; adapt_reg = ADAPT_RST;
            base_seq = 0; next_seq = 0; pend = 0; head = 0; now = 0; mean = 0;
            retired = 0; taken_cnt = 0; tmo = TIMEOUT_RST; fail_flag = 0;
            sends_q.delete();
            o_errors = 0; o_results = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WINDOW_SIZE: win_reg = i_cfg_data[4:0];
                    CFG_INITIAL_TIMEOUT: begin
                        init_tmo = i_cfg_data;
                        if (taken_cnt <= adapt_reg) tmo = init_tmo;
                    end
                    CFG_MAX_ATTEMPTS: max_att = i_cfg_data[3:0];
                    CFG_TOTAL_ACKS: total_reg = i_cfg_data[15:0];
                    CFG_ADAPT_AFTER: adapt_reg = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_pop && !i_empty) begin
                o_results++;
                if (sends_q.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %h", $time, i_out);
                    o_errors++;
                end else begin
                    e = sends_q.pop_front();
                    chk("send_valid", e.send_valid, i_out.send_valid);
                    chk("send_seq", e.send_seq, i_out.send_seq);
                    chk("is_retransmit", e.is_retransmit, i_out.is_retransmit);
                    chk("offer_accepted", e.offer_accepted, i_out.offer_accepted);
                    chk("ack_taken", e.ack_taken, i_out.ack_taken);
                    chk("failed", e.failed, i_out.failed);
                    chk("finished", e.finished, i_out.finished);
                    chk("window_base", e.window_base, i_out.window_base);
                    chk("outstanding", e.outstanding, i_out.outstanding);
                    chk("last", e.last, i_out.last);
                end
            end
            if (i_push && !i_full) predict_sends(i_in);
        end
    end

endmodule

@@ dv/go_back_n_sender_tb.sv @@
// Top of the go-back-n sender testbench: clock, reset, config phases and
// stimulus; the verdict comes from gbn_checker. Depends on gbn_pkg, gbn_checker
// and the go_back_n_sender RTL.
`timescale 1ns / 1ps
module go_back_n_sender_tb;
    import gbn_pkg::*;

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_push = 0;
    logic                  o_full;
    t_in_item              i_in = '0;
    logic                  o_empty;
    logic                  i_pop = 0;
    t_out_item             o_out;
    logic                  i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int               errors, pending, results;
    logic [SEQ_W-1:0] pred_base;
    logic [CNT_W-1:0] pred_count;

    // window state snapshot, taken away from the active edge
    logic [SEQ_W-1:0] snap_base = '0;
    logic [CNT_W-1:0] snap_count = '0;

    int send_idle_pct = 0;   // chance of a gap after each input transfer
    int pop_stall_pct = 0;   // chance of holding off pop in a cycle
    int items_sent = 0;
    int phases_run = 0;

    always #1 i_clk = ~i_clk;

    go_back_n_sender dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_push), .o_full(o_full), .i_in(i_in),
        .o_empty(o_empty), .i_pop(i_pop), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    gbn_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_push), .i_full(o_full), .i_in(i_in),
        .i_empty(o_empty), .i_pop(i_pop), .i_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_base(pred_base), .o_count(pred_count)
    );

    always @(negedge i_clk) begin
        snap_base  <= pred_base;
        snap_count <= pred_count;
    end

    // receiver side: random pop stalls
    always @(posedge i_clk) begin
        i_pop <= ($urandom_range(0, 99) >= pop_stall_pct);
    end

    // one input transfer; called just after a rising edge
    task automatic send(input logic [1:0] m, input logic [7:0] a);
        logic f;
        i_push <= 1'b1;
        i_in   <= '{mode: m, ack_seq: a};
        do begin
            @(negedge i_clk);
            f = o_full;
            @(posedge i_clk);
        end while (f);
        items_sent++;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // wait until every expected result has been taken, then let an ack's
    // worth of engine cycles pass so the block is truly idle
    task automatic drain();
        int n;
        i_push <= 1'b0;
        n = 0;
        @(negedge i_clk);
        while (pending != 0 && n < 200000) begin
            @(negedge i_clk);
            n++;
        end
        repeat (100) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic set_phase(input logic [31:0] w, input logic [31:0] tmo,
                             input logic [31:0] att, input logic [31:0] tot,
                             input logic [31:0] adp, input int idle, input int stall);
        drain();
        cfg_write(CFG_ADAPT_AFTER, adp);
        cfg_write(CFG_WINDOW_SIZE, w);
        cfg_write(CFG_INITIAL_TIMEOUT, tmo);
        cfg_write(CFG_MAX_ATTEMPTS, att);
        cfg_write(CFG_TOTAL_ACKS, tot);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        send_idle_pct = idle;
        pop_stall_pct = stall;
        phases_run++;
    endtask

    // mostly well-formed traffic: offers, acks inside the window, ticks;
    // a little noise with out-of-range acks and the unused mode
    task automatic random_items(input int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 35) send(MODE_OFFER, 8'($urandom));
            else if (r < 65) begin
                if (snap_count != 0 && $urandom_range(0, 9) < 8)
                    send(MODE_ACK, snap_base + 8'($urandom_range(0, snap_count - 1)));
                else
                    send(MODE_ACK, 8'($urandom));
            end else if (r < 95) send(MODE_TICK, 8'($urandom));
            else send(2'd3, 8'($urandom));
        end
    endtask

    initial begin
        int n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: full window, refused offer, stray and cumulative acks,
        // resend walk, idle mode
        set_phase(16, 3, 15, 65535, 255, 0, 0);
        repeat (16) send(MODE_OFFER, 8'h00);
        send(MODE_OFFER, 8'hFF);       // window full
        send(MODE_ACK, 8'hFF);         // outside the range
        send(MODE_ACK, 8'd4);          // retires five at once
        send(2'd3, 8'hAA);
        repeat (5) send(MODE_TICK, 8'h55);  // times out, resends all
        send(MODE_ACK, 8'd15);         // last outstanding
        random_items(80);

        // tightest window, timeout set to 1, adapting right away; sender idles
        set_phase(1, 1, 15, 65535, 0, 83, 0);
        random_items(70);

        // oversize window register, huge timeout; receiver stalls,
        // and one pause mid-phase until every expected result has been taken
        set_phase(31, 32'hFFFF_FFFF, 15, 65535, 3, 0, 83);
        random_items(35);
        drain();
        random_items(35);

        // finish limit reached: every input just reports status
        set_phase(7, 8, 15, 1, 8'hFF, 15, 15);
        random_items(20);

        // zero window acts as one, then back to open running
        set_phase(0, 2, 15, 65535, 128, 0, 0);
        random_items(40);
        set_phase(12, 4, 15, 65535, 8, 15, 15);
        random_items(94);

        // attempt limit of one: failure is sticky, so it comes last
        set_phase(16, 2, 1, 65535, 255, 0, 0);
        random_items(30);

        i_push <= 1'b0;
        n = 0;
        @(negedge i_clk);
        while (pending != 0 && n < 200000) begin
            @(negedge i_clk);
            n++;
        end
        repeat (200) @(posedge i_clk);
        $display("Covered %0d input transfers and %0d results over %0d register settings,",
                 items_sent, results, phases_run);
        $display("including window limits, resend walks, finish and attempt-limit halts.");
        if (errors == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            if (pending != 0)
                $display("%0t ns: %0d expected results never arrived", $time, pending);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t ns: timeout", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ go_back_n_sender.f @@
rtl/gbn_pkg.sv
rtl/gbn_front.sv
rtl/gbn_out_q.sv
rtl/gbn_engine.sv
rtl/go_back_n_sender.sv
dv/gbn_checker.sv
dv/go_back_n_sender_tb.sv
